// ===== hw/rtl/sexpr_model_file_lexer_defines.svh =====
// ----------------------------------------------------------------------------
// sexpr_model_file_lexer_defines
// Assertion helpers for the s-expression lexer.
// ----------------------------------------------------------------------------
// Both expect clk and rst_n in the scope of the use.
`ifndef SEXPR_MODEL_FILE_LEXER_DEFINES_SVH
`define SEXPR_MODEL_FILE_LEXER_DEFINES_SVH

// Same-cycle implication.
`define SML_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SML_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sml_pkg.sv =====
// ----------------------------------------------------------------------------
// sml_pkg
// Types and constants shared by the s-expression lexer modules.
// ----------------------------------------------------------------------------
package sml_pkg;

  localparam int unsigned LineW     = 24;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  localparam logic [LineW-1:0] LINE_MAX = {LineW{1'b1}};

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_ATOM    = 3'd1,
    M_STR     = 3'd2,
    M_STR_ESC = 3'd3,
    M_ML      = 3'd4,
    M_ML_ESC  = 3'd5,
    M_ML_NL   = 3'd6,
    M_ML_NLCR = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    K_TEXT     = 3'd0,
    K_OPEN     = 3'd1,
    K_CLOSE    = 3'd2,
    K_ATOM_END = 3'd3,
    K_STR_END  = 3'd4,
    K_EOF      = 3'd5,
    K_UNTERM   = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } ev_t;

  // Outcome of one item: next mode, line bump and up to two events.
  typedef struct packed {
    mode_t      mode_nxt;
    logic       count_line;
    logic [1:0] n;
    ev_t        ev0;
    ev_t        ev1;
  } step_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data;
    logic [LineW-1:0] line;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       res0;
    res_t       res1;
  } push_t;

  typedef struct packed {
    logic space2;
    logic nonempty;
  } fifo_stat_t;

endpackage

// ===== hw/rtl/sml_if.sv =====
// ----------------------------------------------------------------------------
// sml_in_if / sml_out_if
// Valid/ready channels for raw bytes in and lexer events out.
// ----------------------------------------------------------------------------
interface sml_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_eof;

  modport source (output valid, output in_byte, output is_eof, input ready);
  modport sink   (input valid, input in_byte, input is_eof, output ready);
endinterface

interface sml_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [7:0]  text_byte;
  logic [23:0] line_count;
  logic        last_of_run;

  modport source (output valid, output event_kind, output text_byte,
                  output line_count, output last_of_run, input ready);
  modport sink   (input valid, input event_kind, input text_byte,
                  input line_count, input last_of_run, output ready);
endinterface

// ===== hw/rtl/sml_step.sv =====
// ----------------------------------------------------------------------------
// sml_step
// Next-mode and event decode for one byte or end-of-file mark.
// ----------------------------------------------------------------------------
module sml_step (
  input  sml_pkg::mode_t mode,
  input  logic [7:0]     in_byte,
  input  logic           is_eof,
  output sml_pkg::step_t step
);
  import sml_pkg::*;

  typedef struct packed {
    logic  emit;
    ev_t   ev;
    mode_t mode_nxt;
    logic  count_line;
  } idle_res_t;

  // Byte seen between tokens.
  function automatic idle_res_t idle_byte(input logic [7:0] c);
    idle_res_t r;
    r.emit       = 1'b0;
    r.ev.kind    = K_TEXT;
    r.ev.data    = 8'h00;
    r.mode_nxt   = M_IDLE;
    r.count_line = 1'b0;
    priority if (c == CH_LPAREN) begin
      r.emit    = 1'b1;
      r.ev.kind = K_OPEN;
    end else if (c == CH_RPAREN) begin
      r.emit    = 1'b1;
      r.ev.kind = K_CLOSE;
    end else if (c == CH_NL) begin
      r.count_line = 1'b1;
    end else if (c == CH_SP || c == CH_CR || c == CH_TAB) begin
      r.mode_nxt = M_IDLE;
    end else if (c == CH_DQUOTE) begin
      r.mode_nxt = M_STR;
    end else if (c == CH_BAR) begin
      r.mode_nxt = M_ML;
    end else begin
      r.emit     = 1'b1;
      r.ev.data  = c;
      r.mode_nxt = M_ATOM;
    end
    return r;
  endfunction

  idle_res_t ib;
  logic      atom_delim;

  assign ib = idle_byte(in_byte);
  assign atom_delim = (in_byte == CH_LPAREN) || (in_byte == CH_RPAREN) ||
                      (in_byte == CH_DQUOTE) || (in_byte == CH_NL) ||
                      (in_byte == CH_SP) || (in_byte == CH_CR) || (in_byte == CH_TAB);

  always_comb begin
    step.mode_nxt   = mode;
    step.count_line = 1'b0;
    step.n          = 2'd0;
    step.ev0.kind   = K_TEXT;
    step.ev0.data   = 8'h00;
    step.ev1.kind   = K_TEXT;
    step.ev1.data   = 8'h00;
    unique case (mode)
      M_IDLE: begin
        if (is_eof) begin
          step.n        = 2'd1;
          step.ev0.kind = K_EOF;
        end else begin
          step.n          = {1'b0, ib.emit};
          step.ev0        = ib.ev;
          step.mode_nxt   = ib.mode_nxt;
          step.count_line = ib.count_line;
        end
      end
      M_ATOM: begin
        if (is_eof) begin
          step.n        = 2'd2;
          step.ev0.kind = K_ATOM_END;
          step.ev1.kind = K_EOF;
          step.mode_nxt = M_IDLE;
        end else if (atom_delim) begin
          // atom end, then the delimiter starts the next token
          step.n          = ib.emit ? 2'd2 : 2'd1;
          step.ev0.kind   = K_ATOM_END;
          step.ev1        = ib.ev;
          step.mode_nxt   = ib.mode_nxt;
          step.count_line = ib.count_line;
        end else begin
          step.n        = 2'd1;
          step.ev0.data = in_byte;
        end
      end
      M_STR: begin
        if (is_eof) begin
          step.n        = 2'd1;
          step.ev0.kind = K_UNTERM;
          step.mode_nxt = M_IDLE;
        end else if (in_byte == CH_DQUOTE) begin
          step.n        = 2'd1;
          step.ev0.kind = K_STR_END;
          step.mode_nxt = M_IDLE;
        end else if (in_byte == CH_BSLASH) begin
          step.mode_nxt = M_STR_ESC;
        end else begin
          step.n        = 2'd1;
          step.ev0.data = in_byte;
        end
      end
      M_STR_ESC: begin
        step.n = 2'd1;
        if (is_eof) begin
          step.ev0.kind = K_UNTERM;
          step.mode_nxt = M_IDLE;
        end else begin
          step.ev0.data = in_byte;
          step.mode_nxt = M_STR;
        end
      end
      M_ML: begin
        if (is_eof) begin
          step.n        = 2'd2;
          step.ev0.kind = K_STR_END;
          step.ev1.kind = K_EOF;
          step.mode_nxt = M_IDLE;
        end else if (in_byte == CH_NL) begin
          step.count_line = 1'b1;
          step.mode_nxt   = M_ML_NL;
        end else if (in_byte == CH_CR) begin
          step.mode_nxt = M_ML;
        end else if (in_byte == CH_BSLASH) begin
          step.mode_nxt = M_ML_ESC;
        end else begin
          step.n        = 2'd1;
          step.ev0.data = in_byte;
        end
      end
      M_ML_ESC: begin
        if (is_eof) begin
          step.n        = 2'd2;
          step.ev0.kind = K_STR_END;
          step.ev1.kind = K_EOF;
          step.mode_nxt = M_IDLE;
        end else begin
          step.n        = 2'd1;
          step.ev0.data = in_byte;
          step.mode_nxt = M_ML;
        end
      end
      M_ML_NL, M_ML_NLCR: begin
        if (is_eof) begin
          step.n        = 2'd2;
          step.ev0.kind = K_STR_END;
          step.ev1.kind = K_EOF;
          step.mode_nxt = M_IDLE;
        end else if (in_byte == CH_BAR) begin
          // continuation line: the newline becomes string content
          step.n        = 2'd1;
          step.ev0.data = CH_NL;
          step.mode_nxt = M_ML;
        end else if (in_byte == CH_CR && mode == M_ML_NL) begin
          step.mode_nxt = M_ML_NLCR;
        end else begin
          step.n          = ib.emit ? 2'd2 : 2'd1;
          step.ev0.kind   = K_STR_END;
          step.ev1        = ib.ev;
          step.mode_nxt   = ib.mode_nxt;
          step.count_line = ib.count_line;
        end
      end
      default: begin
        step.mode_nxt = M_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/sml_res_fifo.sv =====
// ----------------------------------------------------------------------------
// sml_res_fifo
// Small result queue: takes up to two events per cycle, hands out one.
// ----------------------------------------------------------------------------
module sml_res_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  sml_pkg::push_t      push,
  input  logic                pop,
  output sml_pkg::res_t       head,
  output sml_pkg::fifo_stat_t stat
);
  import sml_pkg::*;

  res_t            mem_r [FifoDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [PtrW-1:0] wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PtrW'(push.n);
    rd_ptr_nxt = rd_ptr_r + PtrW'(pop);
    cnt_nxt    = cnt_r + CntW'(push.n) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.res1;
    end
  end

  assign head          = mem_r[rd_ptr_r];
  assign stat.nonempty = (cnt_r != '0);
  assign stat.space2   = (cnt_r <= CntW'(FifoDepth - 2));

endmodule

// ===== hw/rtl/sexpr_model_file_lexer.sv =====
// Events are registered in the result queue, which out_ch reads from its head.
// Throughput: one byte per cycle while each byte yields at most one event and
//   out_ch is not stalled; two events from one byte go out in turn on out_ch.
// A four-entry result queue decouples the sides; in_ch.ready needs two free.
// Reset (rst_n low, synchronous): mode idle, line counter one, queue empty.
// ----------------------------------------------------------------------------
// sexpr_model_file_lexer
// Byte-stream tokenizer for s-expression model files.
// ----------------------------------------------------------------------------
`include "sexpr_model_file_lexer_defines.svh"

module sexpr_model_file_lexer (
  input  logic      clk,
  input  logic      rst_n,
  sml_in_if.sink    in_ch,
  sml_out_if.source out_ch
);
  import sml_pkg::*;

  mode_t            mode_r, mode_nxt;
  logic [LineW-1:0] line_r, line_nxt;
  step_t            step;
  logic             in_acc;
  logic             pop;
  push_t            push;
  res_t             head;
  fifo_stat_t       stat;

  sml_step u_step (
    .mode    (mode_r),
    .in_byte (in_ch.in_byte),
    .is_eof  (in_ch.is_eof),
    .step    (step)
  );

  assign in_ch.ready = stat.space2;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;

  always_comb begin
    mode_nxt = mode_r;
    line_nxt = line_r;
    if (in_acc) begin
      mode_nxt = step.mode_nxt;
      if (step.count_line && line_r != LINE_MAX) begin
        line_nxt = line_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      line_r <= LineW'(1);
    end else begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
    end
  end

  // events carry the line count from before this item's newline
  always_comb begin
    push.n         = in_acc ? step.n : 2'd0;
    push.res0.kind = step.ev0.kind;
    push.res0.data = step.ev0.data;
    push.res0.line = line_r;
    push.res0.last = (step.n == 2'd1);
    push.res1.kind = step.ev1.kind;
    push.res1.data = step.ev1.data;
    push.res1.line = line_r;
    push.res1.last = 1'b1;
  end

  sml_res_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .stat  (stat)
  );

  assign out_ch.valid       = stat.nonempty;
  assign out_ch.event_kind  = head.kind;
  assign out_ch.text_byte   = head.data;
  assign out_ch.line_count  = head.line;
  assign out_ch.last_of_run = head.last;

  `SML_ASSERT_NOW(a_line_nonzero, 1'b1, line_r != '0, "line counter reached zero")
  `SML_ASSERT_NEXT(a_line_step, in_acc && step.count_line && line_r != LINE_MAX,
    line_r == $past(line_r) + 1'b1, "line counter did not advance")
  `SML_ASSERT_NEXT(a_line_hold, !(in_acc && step.count_line), line_r == $past(line_r),
    "line counter moved without a counted newline")
  `SML_ASSERT_NOW(a_nontext_zero, out_ch.valid && head.kind != K_TEXT,
    head.data == 8'h00, "non-text event carries a byte")
  `SML_ASSERT_NOW(a_two_need_last, in_acc && step.n == 2'd2,
    step.ev1.kind != K_TEXT || step.mode_nxt == M_ATOM, "second event out of place")

endmodule
